@@ rtl/rwc_pkg.sv @@
`timescale 1ns / 1ps

package rwc_pkg;

    localparam int WINDOW_BYTES_DEF = 1024;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] sum_a;
        logic [31:0] sum_b;
        logic [31:0] window_start;
        logic        partial;
    } out_item_t;

    // Per-byte control that travels from the pointer stage to the sum stage.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        restart;
        logic        last_byte;
        logic        full;
        logic        emit;
        logic        partial;
        logic [31:0] window_start;
    } stage_t;

endpackage

@@ rtl/rwc_ring.sv @@
`timescale 1ns / 1ps

module rwc_ring #(
    parameter int WINDOW_BYTES = rwc_pkg::WINDOW_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(WINDOW_BYTES)-1:0] addr,
    input  logic [7:0]                      wr_data,
    output logic [7:0]                      rd_data
);

    logic [7:0] mem [WINDOW_BYTES];
    logic [7:0] rd_data_reg;

    // Read-first: the byte leaving the window is read in the same cycle that
    // the new byte replaces it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rd_data_reg <= mem[addr];
            mem[addr]   <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rwc_ctrl.sv @@
`timescale 1ns / 1ps

module rwc_ctrl #(
    parameter int WINDOW_BYTES = rwc_pkg::WINDOW_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  rwc_pkg::in_item_t               item,
    input  logic                            b_go,
    output logic [$clog2(WINDOW_BYTES)-1:0] ring_addr,
    output logic                            stage_valid,
    output rwc_pkg::stage_t                 stage
);

    import rwc_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_BYTES);
    localparam int CNT_W = $clog2(WINDOW_BYTES + 1);
    localparam logic [CNT_W-1:0] WIN_CNT  = CNT_W'(WINDOW_BYTES);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(WINDOW_BYTES - 1);

    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [31:0]      offset_reg, offset_next;
    logic             vld_reg, vld_next;
    stage_t           stage_reg, stage_next;

    logic [PTR_W-1:0] ptr_item;
    logic [CNT_W-1:0] fill_item, fill_after;
    logic             full;

    always_comb
    begin
        ptr_item   = item.restart ? '0 : ptr_reg;
        fill_item  = item.restart ? '0 : fill_reg;
        full       = (fill_item == WIN_CNT);
        fill_after = full ? WIN_CNT : fill_item + 1'b1;

        stage_next.data_byte    = item.data_byte;
        stage_next.restart      = item.restart;
        stage_next.last_byte    = item.last_byte;
        stage_next.full         = full;
        stage_next.emit         = (fill_after == WIN_CNT) || item.last_byte;
        stage_next.partial      = (fill_after != WIN_CNT);
        stage_next.window_start = offset_reg + 32'd1 - 32'(fill_after);

        // The last byte of a stream returns the position state to reset.
        if (item.last_byte)
        begin
            ptr_next    = '0;
            fill_next   = '0;
            offset_next = '0;
        end
        else
        begin
            ptr_next    = (ptr_item == LAST_PTR) ? '0 : ptr_item + 1'b1;
            fill_next   = fill_after;
            offset_next = offset_reg + 32'd1;
        end

        if (accept)
            vld_next = 1'b1;
        else if (b_go)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            fill_reg   <= '0;
            offset_reg <= '0;
            vld_reg    <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (accept)
            begin
                ptr_reg    <= ptr_next;
                fill_reg   <= fill_next;
                offset_reg <= offset_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= stage_next;
    end

    assign ring_addr   = ptr_item;
    assign stage_valid = vld_reg;
    assign stage       = stage_reg;

endmodule

@@ rtl/rwc_sums.sv @@
`timescale 1ns / 1ps

module rwc_sums #(
    parameter int WINDOW_BYTES = rwc_pkg::WINDOW_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               stage_valid,
    input  rwc_pkg::stage_t    stage,
    input  logic [7:0]         old_byte,
    input  logic               result_ready,
    output logic               b_go,
    output logic               result_valid,
    output rwc_pkg::out_item_t result
);

    import rwc_pkg::*;

    localparam logic [31:0] WIN32 = 32'(WINDOW_BYTES);

    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic        res_vld_reg, res_vld_next;
    out_item_t   res_reg, res_next;

    logic [31:0] a_base, b_base, d, t, a_new, b_new;
    logic        out_free;

    always_comb
    begin
        a_base = stage.restart ? 32'd1 : a_reg;
        b_base = stage.restart ? 32'd0 : b_reg;

        // While filling, the byte is only added. Once full, the leaving byte
        // is subtracted from A and N times from B.
        if (stage.full)
        begin
            d = 32'(stage.data_byte) - 32'(old_byte);
            t = d - WIN32 * 32'(old_byte) - 32'd1;
        end
        else
        begin
            d = 32'(stage.data_byte);
            t = d;
        end

        a_new = a_base + d;
        b_new = b_base + a_base + t;

        out_free = !res_vld_reg || result_ready;
        b_go     = stage_valid && (!stage.emit || out_free);

        if (b_go && stage.last_byte)
        begin
            a_next = 32'd1;
            b_next = 32'd0;
        end
        else if (b_go)
        begin
            a_next = a_new;
            b_next = b_new;
        end
        else
        begin
            a_next = a_reg;
            b_next = b_reg;
        end

        res_next.sum_a        = a_new;
        res_next.sum_b        = b_new;
        res_next.window_start = stage.window_start;
        res_next.partial      = stage.partial;

        if (b_go && stage.emit)
            res_vld_next = 1'b1;
        else if (result_ready)
            res_vld_next = 1'b0;
        else
            res_vld_next = res_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg       <= 32'd1;
            b_reg       <= 32'd0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            a_reg       <= a_next;
            b_reg       <= b_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_go && stage.emit)
            res_reg <= res_next;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

@@ rtl/rolling_window_checksum.sv @@
`timescale 1ns / 1ps

// Rolling weak checksum (A and B sums, modulo 2^32) over the last WINDOW_BYTES
// bytes of a byte stream.
//
// Input channel item_valid/item_ready/item carries one byte per transfer with
// its restart and last_byte flags. Output channel result_valid/result_ready/
// result carries sum_a, sum_b, window_start and partial. A result is given for
// every byte that leaves the window full, and for a last byte in any case.
// Throughput is one byte per clock while no result is blocked. An accepted
// byte is held in the stage register; the sum stage registers its result.
// The first stage updates the ring pointer and fill count and reads the leaving
// byte from a single-port read-first RAM; the second stage updates the sums.
// Reset clears the window, the sums and the stream offset; the ring itself is
// not cleared and needs no sweep, since a slot is read only after it is
// written. When the receiver stalls, one result waits in the output register
// and one more byte waits in the sum stage; bytes that give no result keep
// flowing until a byte that gives one is blocked, and then item_ready drops.

module rolling_window_checksum #(
    parameter int WINDOW_BYTES = rwc_pkg::WINDOW_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  rwc_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output rwc_pkg::out_item_t result
);

    import rwc_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_BYTES);

    logic             accept;
    logic             b_go;
    logic [PTR_W-1:0] ring_addr;
    logic [7:0]       old_byte;
    logic             stage_valid;
    stage_t           stage;

    assign item_ready = !stage_valid || b_go;
    assign accept     = item_valid && item_ready;

    rwc_ctrl #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .b_go       (b_go),
        .ring_addr  (ring_addr),
        .stage_valid(stage_valid),
        .stage      (stage)
    );

    rwc_ring #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_ring (
        .clk    (clk),
        .wr_en  (accept),
        .addr   (ring_addr),
        .wr_data(item.data_byte),
        .rd_data(old_byte)
    );

    rwc_sums #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_sums (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage       (stage),
        .old_byte    (old_byte),
        .result_ready(result_ready),
        .b_go        (b_go),
        .result_valid(result_valid),
        .result      (result)
    );

    // A partial window is reported only for the final byte of a stream.
    a_partial_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && stage.partial && stage.emit) |-> stage.last_byte)
        else $error("partial result on a byte that is not the last");

    // The last byte of a stream always produces a result.
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last_byte) |=> (stage_valid && stage.emit))
        else $error("last byte did not produce a result");

    // The sum stage only holds a byte when its result is blocked downstream.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && !item_ready) |-> (stage.emit && result_valid && !result_ready))
        else $error("input stalled without a blocked result");

endmodule
